[rtl/itp_pkg.sv]
package itp_pkg;

    localparam int STACK_DEPTH_DEF = 32;

    // operator codes as kept on the stack
    localparam logic [1:0] OP_PLUS  = 2'd0;
    localparam logic [1:0] OP_MINUS = 2'd1;
    localparam logic [1:0] OP_MUL   = 2'd2;
    localparam logic [1:0] OP_DIV   = 2'd3;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;

    // item kinds after classification
    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_OP   = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    typedef struct packed {
        logic       cmd;
        logic [7:0] ch;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       is_terminator;
        logic       overflow;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] code;
        logic [7:0] ch;
    } q_item_t;

    function automatic logic [7:0] op_char(input logic [1:0] code);
        logic [7:0] c;
        case (code)
            OP_PLUS:  c = CH_PLUS;
            OP_MINUS: c = CH_MINUS;
            OP_MUL:   c = CH_MUL;
            OP_DIV:   c = CH_DIV;
            default:  c = CH_PLUS;
        endcase
        return c;
    endfunction

endpackage

[rtl/itp_front.sv]
module itp_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  itp_pkg::in_item_t  in_data,
    output logic               head_valid,
    output itp_pkg::q_item_t   head,
    input  logic               head_pop
);

    // two-entry queue between classification and the stack engine
    itp_pkg::q_item_t q_mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;
    itp_pkg::q_item_t cls;
    logic             push;
    logic             pop;

    always_comb
    begin
        cls.ch   = in_data.ch;
        cls.code = itp_pkg::OP_PLUS;
        cls.kind = itp_pkg::KIND_CHAR;
        if (in_data.cmd)
        begin
            cls.kind = itp_pkg::KIND_END;
        end
        else
        begin
            case (in_data.ch)
                itp_pkg::CH_PLUS:
                begin
                    cls.kind = itp_pkg::KIND_OP;
                    cls.code = itp_pkg::OP_PLUS;
                end
                itp_pkg::CH_MINUS:
                begin
                    cls.kind = itp_pkg::KIND_OP;
                    cls.code = itp_pkg::OP_MINUS;
                end
                itp_pkg::CH_MUL:
                begin
                    cls.kind = itp_pkg::KIND_OP;
                    cls.code = itp_pkg::OP_MUL;
                end
                itp_pkg::CH_DIV:
                begin
                    cls.kind = itp_pkg::KIND_OP;
                    cls.code = itp_pkg::OP_DIV;
                end
                default:
                begin
                    cls.kind = itp_pkg::KIND_CHAR;
                end
            endcase
        end
    end

    assign in_ready   = (cnt_reg != 2'd2);
    assign push       = in_valid && in_ready;
    assign head_valid = (cnt_reg != 2'd0);
    assign pop        = head_pop && head_valid;
    assign head       = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

[rtl/itp_back.sv]
module itp_back
#(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  itp_pkg::q_item_t   head,
    output logic               head_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output itp_pkg::out_item_t out_data
);

    localparam int CW        = $clog2(STACK_DEPTH + 1);
    localparam int AW        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int MEM_DEPTH = 2 ** AW;

    logic [1:0]         mem [MEM_DEPTH];
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      cnt_next;
    logic [1:0]         top_reg;
    logic [1:0]         top_next;
    logic [1:0]         sec_reg;
    logic               out_valid_reg;
    itp_pkg::out_item_t out_reg;

    logic               can_emit;
    logic               emit;
    itp_pkg::out_item_t emit_item;
    logic               push;
    logic               pop;
    logic               is_empty;
    logic               is_full;
    logic               has_two;
    logic               pop_ok;
    logic               more;
    logic [CW-1:0]      wr_cnt;
    logic [CW-1:0]      rd_cnt;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;

    assign can_emit = !out_valid_reg || out_ready;
    assign is_empty = (cnt_reg == '0);
    assign is_full  = (cnt_reg == CW'(STACK_DEPTH));
    assign has_two  = (cnt_reg > CW'(1));
    // top ranks at least the incoming operator: rank is high for * and /
    assign pop_ok   = !is_empty && (top_reg[1] || !head.code[1]);
    assign more     = has_two && (sec_reg[1] || !head.code[1]);

    always_comb
    begin
        emit      = 1'b0;
        emit_item = '0;
        push      = 1'b0;
        pop       = 1'b0;
        head_pop  = 1'b0;
        if (head_valid)
        begin
            case (head.kind)
                itp_pkg::KIND_CHAR:
                begin
                    if (can_emit)
                    begin
                        emit               = 1'b1;
                        emit_item.out_char = head.ch;
                        emit_item.last     = 1'b1;
                        head_pop           = 1'b1;
                    end
                end
                itp_pkg::KIND_END:
                begin
                    if (can_emit)
                    begin
                        emit = 1'b1;
                        if (!is_empty)
                        begin
                            emit_item.out_char = itp_pkg::op_char(top_reg);
                            pop                = 1'b1;
                        end
                        else
                        begin
                            emit_item.is_terminator = 1'b1;
                            emit_item.last          = 1'b1;
                            head_pop                = 1'b1;
                        end
                    end
                end
                itp_pkg::KIND_OP:
                begin
                    if (pop_ok)
                    begin
                        if (can_emit)
                        begin
                            emit               = 1'b1;
                            emit_item.out_char = itp_pkg::op_char(top_reg);
                            emit_item.last     = !more;
                            pop                = 1'b1;
                            // final pop: the operator takes the freed slot
                            if (!more)
                            begin
                                push     = 1'b1;
                                head_pop = 1'b1;
                            end
                        end
                    end
                    else if (!is_full)
                    begin
                        push     = 1'b1;
                        head_pop = 1'b1;
                    end
                    else if (can_emit)
                    begin
                        emit               = 1'b1;
                        emit_item.overflow = 1'b1;
                        emit_item.last     = 1'b1;
                        head_pop           = 1'b1;
                    end
                end
                default:
                begin
                    head_pop = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        top_next = top_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
        if (push)
        begin
            top_next = head.code;
        end
        else if (pop)
        begin
            top_next = sec_reg;
        end
    end

    // top lives in top_reg; memory read keeps sec_reg at the entry below it
    assign wr_cnt  = cnt_next - CW'(1);
    assign rd_cnt  = cnt_next - CW'(2);
    assign wr_addr = wr_cnt[AW-1:0];
    assign rd_addr = rd_cnt[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_addr] <= head.code;
        end
        sec_reg <= mem[rd_addr];
        top_reg <= top_next;
        if (emit)
        begin
            out_reg <= emit_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

[rtl/infix_to_postfix_converter_core.sv]
// infix to postfix converter (shunting-yard, no parentheses). each input transaction carries
// one expression character or an end command; each output transaction carries one postfix
// character, the terminator (out_char 0) or an overflow status, with last marking the final
// result of an input. an operator that pops nothing and fits on the stack gives no output.
// a two-entry queue sits between the classifying front end and the stack engine, which
// pops one operator per cycle while the output is not stalled. an operator pops every
// stacked operator of equal or higher rank before it is pushed; an end command pops the
// whole stack and then emits the terminator. the stack holds up to STACK_DEPTH entries in
// a memory with the top kept in a register; it needs no clearing after reset.
module infix_to_postfix_converter_core
#(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  itp_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output itp_pkg::out_item_t out_data
);

    logic             head_valid;
    logic             head_pop;
    itp_pkg::q_item_t head;

    itp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop)
    );

    itp_back
    #(
        .STACK_DEPTH (STACK_DEPTH)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule
